/* design/frm_pkg.sv */
`default_nettype none

package frm_pkg;

    // Default depth of both averaging windows.
    localparam int DEFAULT_WINDOW_DEPTH = 64;

    // Field widths of the stream payloads.
    localparam int DURATION_W  = 32;
    localparam int RATE_W      = 16;
    localparam int OUT_TDATA_W = 2 * RATE_W + 2 * DURATION_W;

    // Time accumulator width; the accumulator saturates at all ones.
    localparam int ACC_W = 34;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_WS_W   = 7;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_WINDOW_SIZE   = 1'b0;
    localparam logic REG_ONE_SECOND_NS = 1'b1;

    // Register reset values.
    localparam logic [DURATION_W-1:0] RESET_ONE_SECOND_NS = 32'd1000000000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic update;
        logic div_start;
        logic out_load;
    } frm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ft_div_busy;
        logic rt_div_busy;
    } frm_status_t;

endpackage

`default_nettype wire

/* design/frm_div.sv */
`default_nettype none

module frm_div #(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR_W  = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       busy,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    // One restoring step per cycle: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial    = shifted - {1'b0, dsr_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIVIDEND_W);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[DIVISOR_W])
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

endmodule

`default_nettype wire

/* design/frm_regs.sv */
`default_nettype none

module frm_regs
    import frm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [APB_ADDR_W-1:0]                paddr,
    input  wire logic [APB_DATA_W-1:0]                pwdata,
    output logic [APB_DATA_W-1:0]                     prdata,
    output logic                                      pready,
    output logic [$clog2(WINDOW_DEPTH + 1)-1:0]       window_size,
    output logic [DURATION_W-1:0]                     one_second_ns,
    output logic                                      win_clear
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    logic                  wr_en;
    logic [31:0]           ws_req;
    logic [31:0]           ws_clamped;
    logic [CNT_W-1:0]      ws_reg;
    logic [CNT_W-1:0]      ws_next;
    logic [DURATION_W-1:0] period_reg;
    logic [DURATION_W-1:0] period_next;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // The window size is clamped to the range of the stores.
    always_comb
    begin
        ws_req = {{(32 - CFG_WS_W){1'b0}}, pwdata[CFG_WS_W-1:0]};
        if (ws_req == 32'd0)
        begin
            ws_clamped = 32'd1;
        end
        else if (ws_req > 32'(WINDOW_DEPTH))
        begin
            ws_clamped = 32'(WINDOW_DEPTH);
        end
        else
        begin
            ws_clamped = ws_req;
        end
    end

    // Register write decode.
    always_comb
    begin
        ws_next     = ws_reg;
        period_next = period_reg;
        win_clear   = 1'b0;
        if (wr_en)
        begin
            case (paddr[2])
                REG_WINDOW_SIZE:
                begin
                    ws_next   = ws_clamped[CNT_W-1:0];
                    win_clear = 1'b1;
                end
                REG_ONE_SECOND_NS:
                begin
                    period_next = pwdata[DURATION_W-1:0];
                end
                default:
                begin
                    ws_next = ws_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg     <= CNT_W'(1);
            period_reg <= RESET_ONE_SECOND_NS;
        end
        else
        begin
            ws_reg     <= ws_next;
            period_reg <= period_next;
        end
    end

    // Read back.
    always_comb
    begin
        case (paddr[2])
            REG_WINDOW_SIZE:   prdata = {{(APB_DATA_W - CNT_W){1'b0}}, ws_reg};
            REG_ONE_SECOND_NS: prdata = period_reg;
            default:           prdata = '0;
        endcase
    end

    assign window_size   = ws_reg;
    assign one_second_ns = period_reg;

endmodule

`default_nettype wire

/* design/frm_ctrl.sv */
`default_nettype none

module frm_ctrl
    import frm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire frm_status_t status,
    output frm_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_START  = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_OUT    = 5'b10000
    } frm_state_t;

    frm_state_t state_reg;
    frm_state_t state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencing of one transaction: update stores, run both dividers, hand off the result.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.ft_div_busy && !status.rt_div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag of the result register.
    always_comb
    begin
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

/* design/frm_datapath.sv */
`default_nettype none

module frm_datapath
    import frm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire frm_cmd_t                          cmd,
    output frm_status_t                            status,
    input  wire logic                              win_clear,
    input  wire logic [$clog2(WINDOW_DEPTH + 1)-1:0] window_size,
    input  wire logic [DURATION_W-1:0]             one_second_ns,
    input  wire logic [DURATION_W-1:0]             in_duration,
    output logic [OUT_TDATA_W-1:0]                 out_tdata
);

    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int PTR_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FT_SUM_W  = DURATION_W + $clog2(WINDOW_DEPTH);
    localparam int RT_SUM_W  = RATE_W + $clog2(WINDOW_DEPTH);

    // Next slot of a circular window of the configured size.
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
                                                   input logic [CNT_W-1:0] ws);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(p) + CNT_W'(1);
        return (inc >= ws) ? '0 : inc[PTR_W-1:0];
    endfunction

    // Window stores.
    logic [DURATION_W-1:0] ft_store_reg [WINDOW_DEPTH];
    logic [RATE_W-1:0]     rt_store_reg [WINDOW_DEPTH];
    logic [DURATION_W-1:0] ft_rd_reg;
    logic [RATE_W-1:0]     rt_rd_reg;

    // Item and accumulation state.
    logic [DURATION_W-1:0] d_reg;
    logic [RATE_W-1:0]     frames_reg;
    logic [RATE_W-1:0]     frames_next;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      acc_next;
    logic [ACC_W:0]        acc_sum;

    // Window bookkeeping.
    logic [PTR_W-1:0]      ft_ptr_reg;
    logic [PTR_W-1:0]      ft_ptr_next;
    logic                  ft_full_reg;
    logic                  ft_full_next;
    logic [FT_SUM_W-1:0]   ft_sum_reg;
    logic [FT_SUM_W-1:0]   ft_sum_next;
    logic [PTR_W-1:0]      rt_ptr_reg;
    logic [PTR_W-1:0]      rt_ptr_next;
    logic [PTR_W-1:0]      rt_slot_reg;
    logic [PTR_W-1:0]      rt_slot_calc;
    logic                  rt_zero_wr_reg;
    logic                  rt_zero_wr_next;
    logic [CNT_W-1:0]      rt_entries_reg;
    logic [CNT_W-1:0]      rt_entries_next;
    logic [RT_SUM_W-1:0]   rt_sum_reg;
    logic [RT_SUM_W-1:0]   rt_sum_next;
    logic [RATE_W-1:0]     last_rate_reg;
    logic [RATE_W-1:0]     last_rate_next;

    logic                  period_hit;
    logic                  rt_full;
    logic [DURATION_W-1:0] ft_old;
    logic [RATE_W-1:0]     rt_old;
    logic [PTR_W-1:0]      ft_ptr_inc;

    // Divider results, busy flags and the output register.
    logic [FT_SUM_W-1:0]   ft_quo;
    logic [RT_SUM_W-1:0]   rt_quo;
    logic                  ft_div_busy;
    logic                  rt_div_busy;
    logic [RATE_W-1:0]     out_cur_fps_reg;
    logic [RATE_W-1:0]     out_smooth_fps_reg;
    logic [DURATION_W-1:0] out_ft_reg;
    logic [DURATION_W-1:0] out_smooth_ft_reg;

    assign rt_slot_calc = next_slot(rt_ptr_reg, window_size);
    assign ft_ptr_inc   = next_slot(ft_ptr_reg, window_size);
    assign acc_sum      = {1'b0, acc_reg} + (ACC_W + 1)'(in_duration);
    assign period_hit   = (acc_reg >= ACC_W'(one_second_ns));
    assign rt_full      = (rt_entries_reg == window_size);

    // Entries never written since the last clear read as zero.
    assign ft_old = ft_full_reg ? ft_rd_reg : '0;
    assign rt_old = (rt_full && ((rt_slot_reg != '0) || rt_zero_wr_reg)) ? rt_rd_reg : '0;

    // Frame count and time accumulator: count on accept, close a period on update.
    always_comb
    begin
        frames_next = frames_reg;
        acc_next    = acc_reg;
        if (cmd.load)
        begin
            if (frames_reg != {RATE_W{1'b1}})
            begin
                frames_next = frames_reg + 1'b1;
            end
            acc_next = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        end
        else if (cmd.update && period_hit)
        begin
            frames_next = '0;
            acc_next    = acc_reg - ACC_W'(one_second_ns);
        end
    end

    // Window pushes on update (the rate window only when a period closes); a window size write empties both windows.
    always_comb
    begin
        ft_ptr_next     = ft_ptr_reg;
        ft_full_next    = ft_full_reg;
        ft_sum_next     = ft_sum_reg;
        rt_ptr_next     = rt_ptr_reg;
        rt_zero_wr_next = rt_zero_wr_reg;
        rt_entries_next = rt_entries_reg;
        rt_sum_next     = rt_sum_reg;
        last_rate_next  = last_rate_reg;
        if (win_clear)
        begin
            ft_ptr_next     = '0;
            ft_full_next    = 1'b0;
            ft_sum_next     = '0;
            rt_ptr_next     = '0;
            rt_zero_wr_next = 1'b0;
            rt_entries_next = CNT_W'(1);
            rt_sum_next     = '0;
            last_rate_next  = '0;
        end
        else if (cmd.update)
        begin
            ft_ptr_next  = ft_ptr_inc;
            ft_full_next = ft_full_reg || (ft_ptr_inc == '0);
            ft_sum_next  = ft_sum_reg - FT_SUM_W'(ft_old) + FT_SUM_W'(d_reg);
            if (period_hit)
            begin
                rt_ptr_next     = rt_slot_reg;
                rt_zero_wr_next = rt_zero_wr_reg || (rt_slot_reg == '0);
                if (!rt_full)
                begin
                    rt_entries_next = rt_entries_reg + 1'b1;
                end
                rt_sum_next    = rt_sum_reg - RT_SUM_W'(rt_old) + RT_SUM_W'(frames_reg);
                last_rate_next = frames_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg     <= '0;
            acc_reg        <= '0;
            ft_ptr_reg     <= '0;
            ft_full_reg    <= 1'b0;
            ft_sum_reg     <= '0;
            rt_ptr_reg     <= '0;
            rt_zero_wr_reg <= 1'b0;
            rt_entries_reg <= CNT_W'(1);
            rt_sum_reg     <= '0;
            last_rate_reg  <= '0;
        end
        else
        begin
            frames_reg     <= frames_next;
            acc_reg        <= acc_next;
            ft_ptr_reg     <= ft_ptr_next;
            ft_full_reg    <= ft_full_next;
            ft_sum_reg     <= ft_sum_next;
            rt_ptr_reg     <= rt_ptr_next;
            rt_zero_wr_reg <= rt_zero_wr_next;
            rt_entries_reg <= rt_entries_next;
            rt_sum_reg     <= rt_sum_next;
            last_rate_reg  <= last_rate_next;
        end
    end

    // Store reads on accept, store writes on update.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg       <= in_duration;
            ft_rd_reg   <= ft_store_reg[ft_ptr_reg];
            rt_rd_reg   <= rt_store_reg[rt_slot_calc];
            rt_slot_reg <= rt_slot_calc;
        end
        if (cmd.update)
        begin
            ft_store_reg[ft_ptr_reg] <= d_reg;
            if (period_hit)
            begin
                rt_store_reg[rt_slot_reg] <= frames_reg;
            end
        end
    end

    // Mean frame time: running sum over the window size.
    frm_div #(
        .DIVIDEND_W (FT_SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_ft_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (ft_sum_reg),
        .divisor  (window_size),
        .busy     (ft_div_busy),
        .quotient (ft_quo)
    );

    // Mean rate: running sum over the entries held.
    frm_div #(
        .DIVIDEND_W (RT_SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_rt_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rt_sum_reg),
        .divisor  (rt_entries_reg),
        .busy     (rt_div_busy),
        .quotient (rt_quo)
    );

    // Status back to the controller.
    always_comb
    begin
        status.ft_div_busy = ft_div_busy;
        status.rt_div_busy = rt_div_busy;
    end

    // Result register, held while the downstream side stalls.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_cur_fps_reg    <= last_rate_reg;
            out_smooth_fps_reg <= rt_quo[RATE_W-1:0];
            out_ft_reg         <= d_reg;
            out_smooth_ft_reg  <= ft_quo[DURATION_W-1:0];
        end
    end

    assign out_tdata = {out_smooth_ft_reg, out_ft_reg, out_smooth_fps_reg, out_cur_fps_reg};

endmodule

`default_nettype wire

/* design/frame_rate_meter_moving_average.sv */
// An accepted input transaction is loaded, the stores and counters are updated, both dividers
// are started and run, and the results go into the output register, which raises m_tvalid.
// A new item is accepted only once the previous result is loaded, so the item rate is set by
// the bit-serial divider that forms the mean frame time, one quotient bit per cycle, and by m_tready stalls.
// Reset clears all control state, the counters and the sums; the window stores are not swept,
// fill flags mark their entries as zero until written, so the block is ready at once.
`default_nettype none

module frame_rate_meter_moving_average
    import frm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [DURATION_W-1:0]  s_tdata,   // [31:0] frame_duration_ns
    // Output stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [15:0] current_fps, [31:16] smooth_fps,
                                                   // [63:32] frame_time_ns,
                                                   // [95:64] smooth_frame_time_ns
    // Configuration port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    frm_cmd_t              cmd;
    frm_status_t           status;
    logic [CNT_W-1:0]      window_size;
    logic [DURATION_W-1:0] one_second_ns;
    logic                  win_clear;

    // Configuration registers.
    frm_regs #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .window_size   (window_size),
        .one_second_ns (one_second_ns),
        .win_clear     (win_clear)
    );

    // Transaction sequencing.
    frm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Counters, window stores, dividers and the result register.
    frm_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .win_clear     (win_clear),
        .window_size   (window_size),
        .one_second_ns (one_second_ns),
        .in_duration   (s_tdata),
        .out_tdata     (m_tdata)
    );

endmodule

`default_nettype wire
